[rtl/hjs_pkg.sv]
package hjs_pkg;

	localparam int MAX_COLS       = 1024;
	localparam int MAX_ROWS       = 1024;
	localparam int TEMP_FRAC_BITS = 15;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int DIM_W  = 11;
	localparam int TEMP_W = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// Q1.15 constants: 1.0 and 0.2 (rounded)
	localparam int TEMP_ONE     = 1 << TEMP_FRAC_BITS;
	localparam int BOUNDARY_RST = (2 * TEMP_ONE + 5) / 10;
	localparam int DIM_RST      = 800;

	localparam logic [IDX_W-1:0] REG_NUM_ROWS      = 2'd0;
	localparam logic [IDX_W-1:0] REG_NUM_COLS      = 2'd1;
	localparam logic [IDX_W-1:0] REG_BOUNDARY_TEMP = 2'd2;
	localparam logic [IDX_W-1:0] REG_FIRE_TEMP     = 2'd3;

	typedef struct packed {
		logic [DIM_W-1:0]  num_rows;
		logic [DIM_W-1:0]  num_cols;
		logic [TEMP_W-1:0] boundary_temp;
		logic [TEMP_W-1:0] fire_temp;
	} cfg_t;

	typedef struct packed {
		logic              rd_en;
		logic [COL_W-1:0]  rd_next_addr;
		logic [COL_W-1:0]  rd_cur_addr;
		logic              wr_en;
		logic [COL_W-1:0]  wr_addr;
		logic [TEMP_W:0]   wr_prev_data;
		logic [TEMP_W-1:0] wr_older_data;
	} ls_req_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temp;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              done;
	} res_t;

endpackage

[rtl/hjs_cfg_regs.sv]
module hjs_cfg_regs (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [hjs_pkg::IDX_W-1:0] cfg_index,
	input  logic [hjs_pkg::CFG_W-1:0] cfg_data,
	output hjs_pkg::cfg_t            cfg
);
	import hjs_pkg::*;

	cfg_t             cfg_q;
	logic [DIM_W-1:0] raw_dim;
	logic [DIM_W-1:0] rows_sat;
	logic [DIM_W-1:0] cols_sat;

	assign raw_dim = cfg_data[DIM_W-1:0];

	// saturate geometry to the supported range
	always_comb begin
		if (raw_dim < DIM_W'(3)) begin
			rows_sat = DIM_W'(3);
			cols_sat = DIM_W'(3);
		end else begin
			rows_sat = (raw_dim > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : raw_dim;
			cols_sat = (raw_dim > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : raw_dim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows      <= DIM_W'(DIM_RST);
			cfg_q.num_cols      <= DIM_W'(DIM_RST);
			cfg_q.boundary_temp <= TEMP_W'(BOUNDARY_RST);
			cfg_q.fire_temp     <= TEMP_W'(TEMP_ONE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_ROWS:      cfg_q.num_rows      <= rows_sat;
				REG_NUM_COLS:      cfg_q.num_cols      <= cols_sat;
				REG_BOUNDARY_TEMP: cfg_q.boundary_temp <= cfg_data[TEMP_W-1:0];
				REG_FIRE_TEMP:     cfg_q.fire_temp     <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/hjs_line_store.sv]
module hjs_line_store (
	input  logic                        clk,
	input  hjs_pkg::ls_req_t            req,
	output logic [hjs_pkg::TEMP_W:0]    prev_rd,
	output logic [hjs_pkg::TEMP_W-1:0]  older_rd
);
	import hjs_pkg::*;

	// previous row with fire flag on top, and the row before it
	logic [TEMP_W:0]   prev_mem  [MAX_COLS];
	logic [TEMP_W-1:0] older_mem [MAX_COLS];
	logic [TEMP_W:0]   prev_rd_q;
	logic [TEMP_W-1:0] older_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			prev_mem[req.wr_addr]  <= req.wr_prev_data;
			older_mem[req.wr_addr] <= req.wr_older_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			prev_rd_q  <= prev_mem[req.rd_next_addr];
			older_rd_q <= older_mem[req.rd_cur_addr];
		end
	end

	assign prev_rd  = prev_rd_q;
	assign older_rd = older_rd_q;

endmodule

[rtl/hjs_out_buf.sv]
module hjs_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             a_valid,
	input  hjs_pkg::res_t    res_a,
	input  logic             b_valid,
	input  hjs_pkg::res_t    res_b,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_stall,
	output hjs_pkg::res_t    res_out
);
	import hjs_pkg::*;

	logic out_v_q;
	logic pend_q;
	res_t out_q;
	res_t pend_res_q;
	logic out_go;

	assign out_go   = out_v_q && !out_stall;
	assign can_load = !out_v_q || (out_go && !pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
			pend_q  <= a_valid && b_valid;
		end else if (out_go) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q      <= a_valid ? res_a : res_b;
			pend_res_q <= res_b;
		end else if (out_go && pend_q) begin
			out_q <= pend_res_q;
		end
	end

	assign out_valid = out_v_q;
	assign res_out   = out_q;

endmodule

[rtl/heat_jacobi_stencil.sv]
// Path: an accepted cell passes stage 1, then the output buffer; a last-row
// cell's own result follows once its first beat is taken. Throughput: one cell
// per cycle while out_stall is low; last-row cells give two beats each, held
// to the single output beat per cycle. Line stores: one read and one write
// port each. Reset (arst_n low, asynchronous) sets counters, valid flags and
// config registers to defaults; line stores stay undefined until written.
module heat_jacobi_stencil (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hjs_pkg::IDX_W-1:0]       cfg_index,
	input  logic [hjs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [hjs_pkg::TEMP_W-1:0]      cell_temp,
	input  logic                            is_fire,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hjs_pkg::TEMP_W-1:0]      new_temp,
	output logic [hjs_pkg::ROW_W-1:0]       out_row,
	output logic [hjs_pkg::COL_W-1:0]       out_col,
	output logic                            frame_done
);
	import hjs_pkg::*;

	cfg_t    cfg;
	ls_req_t ls_req;
	res_t    res_a;
	res_t    res_b;
	res_t    res_out;

	logic [TEMP_W:0]   prev_rd;
	logic [TEMP_W-1:0] older_rd;

	// raster position of the next input cell
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             in_go;
	logic             last_col_a;
	logic             last_row_a;
	logic             has_a_a;
	logic             edge_a;
	logic [DIM_W-1:0] row_ext;
	logic [DIM_W-1:0] row_m1;
	logic [COL_W-1:0] next_addr;

	// stage 1: cell waits here for its line store reads
	logic              v_s1;
	logic [TEMP_W-1:0] temp_s1;
	logic              fire_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [COL_W-1:0]  col_s1;
	logic              has_a_s1;
	logic              edge_s1;
	logic              last_row_s1;
	logic              last_col_s1;
	logic [TEMP_W:0]   here_s1;

	// west neighbor: center value of the cell just before in this row
	logic [TEMP_W-1:0] west_q;

	logic              s1_go;
	logic              s1_has_res;
	logic              can_load;
	logic [TEMP_W+1:0] sum_s1;

	hjs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ---- accept side -------------------------------------------------------
	assign in_go = in_valid && !in_stall;

	assign row_ext    = {1'b0, row_q};
	assign row_m1     = row_ext - DIM_W'(1);
	assign last_col_a = {1'b0, col_q} >= (cfg.num_cols - DIM_W'(1));
	assign last_row_a = row_ext >= (cfg.num_rows - DIM_W'(1));
	assign has_a_a    = (row_q != '0);

	// the emitted cell (row-1, col) sits on the grid edge
	assign edge_a = (row_q == ROW_W'(1)) || (row_m1 >= (cfg.num_rows - DIM_W'(1))) ||
		(col_q == '0) || last_col_a;

	// prefetch the next cell's center; it doubles as this cell's east neighbor
	assign next_addr = last_col_a ? '0 : col_q + COL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_go) begin
			if (last_col_a) begin
				col_q <= '0;
				row_q <= last_row_a ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ---- stage 1 -----------------------------------------------------------
	assign s1_has_res = has_a_s1 || last_row_s1;
	assign s1_go      = v_s1 && (!s1_has_res || can_load);
	assign in_stall   = v_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_go) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			temp_s1     <= cell_temp;
			fire_s1     <= is_fire;
			row_s1      <= row_q;
			col_s1      <= col_q;
			has_a_s1    <= has_a_a;
			edge_s1     <= edge_a;
			last_row_s1 <= last_row_a;
			last_col_s1 <= last_col_a;
			// read data still holds the prefetch made by the previous cell
			here_s1     <= prev_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			west_q <= here_s1[TEMP_W-1:0];
		end
	end

	// read at accept, write back when the cell leaves stage 1; the addresses
	// in flight never meet since a row has at least three columns
	always_comb begin
		ls_req.rd_en         = in_go;
		ls_req.rd_next_addr  = next_addr;
		ls_req.rd_cur_addr   = col_q;
		ls_req.wr_en         = s1_go;
		ls_req.wr_addr       = col_s1;
		ls_req.wr_prev_data  = {fire_s1, temp_s1};
		ls_req.wr_older_data = here_s1[TEMP_W-1:0];
	end

	hjs_line_store u_ls (
		.clk      (clk),
		.req      (ls_req),
		.prev_rd  (prev_rd),
		.older_rd (older_rd)
	);

	// north + south + west + east, truncated mean
	assign sum_s1 = (TEMP_W+2)'(older_rd) + (TEMP_W+2)'(temp_s1) +
		(TEMP_W+2)'(west_q) + (TEMP_W+2)'(prev_rd[TEMP_W-1:0]);

	always_comb begin
		res_a.row  = row_s1 - ROW_W'(1);
		res_a.col  = col_s1;
		res_a.done = 1'b0;
		if (here_s1[TEMP_W]) begin
			res_a.temp = cfg.fire_temp;
		end else if (edge_s1) begin
			res_a.temp = cfg.boundary_temp;
		end else begin
			res_a.temp = sum_s1[TEMP_W+1:2];
		end
	end

	// last-row cell: its own value is always an edge value
	always_comb begin
		res_b.temp = fire_s1 ? cfg.fire_temp : cfg.boundary_temp;
		res_b.row  = row_s1;
		res_b.col  = col_s1;
		res_b.done = last_col_s1;
	end

	// ---- output ------------------------------------------------------------
	hjs_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_go && s1_has_res),
		.a_valid   (has_a_s1),
		.res_a     (res_a),
		.b_valid   (last_row_s1),
		.res_b     (res_b),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign new_temp   = res_out.temp;
	assign out_row    = res_out.row;
	assign out_col    = res_out.col;
	assign frame_done = res_out.done;

endmodule

[rtl/hjs_checker.sv]
module hjs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [hjs_pkg::TEMP_W-1:0]      new_temp,
	input logic [hjs_pkg::ROW_W-1:0]       out_row,
	input logic [hjs_pkg::COL_W-1:0]       out_col,
	input logic                            frame_done
);
	import hjs_pkg::*;

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(new_temp) && $stable(out_row) &&
			$stable(out_col) && $stable(frame_done))
		else $error("result payload changed while stalled");

	// nothing comes out right after reset
	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

	// a frame end is never followed at once by another frame end
	a_done_apart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_done |=> !(out_valid && frame_done))
		else $error("two frame ends in consecutive beats");

endmodule

bind heat_jacobi_stencil hjs_checker u_hjs_checker (.*);
